// ===== rtl/core/tcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// shared types and constants of the text console cursor engine
// ----------------------------------------------------------------------------
package tcc_pkg;

    // largest screen the engine addresses
    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;
    // tab stop spacing in columns
    localparam int TAB_STOP = 4;

    // input operation codes
    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_SETPOS = 2'd1;
    localparam logic [1:0] OP_HOME   = 2'd2;

    // control characters
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // result kinds
    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_FG      = 2'd2;

    localparam logic [7:0]  COLUMNS_RESET = 8'd80;
    localparam logic [6:0]  ROWS_RESET    = 7'd25;
    localparam logic [23:0] FG_RESET      = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] character;
        logic [6:0] pos_x;
        logic [5:0] pos_y;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  screen_row;
        logic [6:0]  screen_col;
        logic [5:0]  store_row;
        logic [7:0]  cell_char;
        logic [23:0] cell_color;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0]  columns;
        logic [6:0]  rows;
        logic [23:0] foreground_color;
    } cfg_t;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_PRINT,
        CMD_LF,
        CMD_CR,
        CMD_BS,
        CMD_TAB,
        CMD_SETPOS,
        CMD_HOME
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] character;
        logic [6:0] pos_x;
        logic [5:0] pos_y;
    } cmd_t;

    localparam int CMD_W    = $bits(cmd_t);
    localparam int RESULT_W = $bits(result_t);

endpackage
`default_nettype wire

// ===== rtl/core/text_console_cursor_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an item's results pass from the command queue through the back end sequencer and the result queue to the result ports
// the back end sequencer takes one item at a time, a new one only when the last is done;
//   a tab writes its cells in turn, a wrapping print wraps before it writes, an oversized
//   offset is first cut by row count subtractions; writes wait on a full result queue
// reset: cursor and row offset at 0, registers at 80 x 25 and white, both queues empty;
//   the cell store lives downstream and is filled from the reported items
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// text console cursor engine: cursor, wrap, tab and circular scroll
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top
    import tcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item side
    input  wire logic        push,
    input  wire item_t       item,
    output logic             full,
    // result side
    output logic             empty,
    input  wire logic        pop,
    output result_t          result,
    // configuration write port
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    // configuration registers
    cfg_t cfg_reg, cfg_next;

    // front to back command queue
    cmd_t cmd;
    logic cmd_empty;
    logic cmd_pop;

    // back to result queue
    logic                res_push;
    result_t             res;
    logic                res_full;
    logic [RESULT_W-1:0] result_bits;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_COLUMNS: cfg_next.columns          = cfg_data[7:0];
                REG_ROWS:    cfg_next.rows             = cfg_data[6:0];
                REG_FG:      cfg_next.foreground_color = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns          <= COLUMNS_RESET;
            cfg_reg.rows             <= ROWS_RESET;
            cfg_reg.foreground_color <= FG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: decode and queue each item
    tcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    // back: one command at a time, stalls while the result queue is full
    tcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    // result queue parts the back end from the consumer
    tcc_fifo #(
        .WIDTH (RESULT_W)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result_bits),
        .empty (empty)
    );

    assign result = result_t'(result_bits);

endmodule
`default_nettype wire

// ===== rtl/core/tcc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_fifo
// two-entry register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module tcc_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tcc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_front
// accepts items, decodes them into commands and queues them for the back end
// ----------------------------------------------------------------------------
module tcc_front
    import tcc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t item,
    output logic       full,
    input  wire logic  cmd_pop,
    output cmd_t       cmd,
    output logic       cmd_empty
);

    cmd_t             decoded;
    logic [CMD_W-1:0] cmd_bits;

    always_comb
    begin
        decoded.character = item.character;
        decoded.pos_x     = item.pos_x;
        decoded.pos_y     = item.pos_y;
        case (item.operation)
            OP_PUT:
            begin
                case (item.character)
                    CH_LF:   decoded.kind = CMD_LF;
                    CH_CR:   decoded.kind = CMD_CR;
                    CH_BS:   decoded.kind = CMD_BS;
                    CH_TAB:  decoded.kind = CMD_TAB;
                    default: decoded.kind = CMD_PRINT;
                endcase
            end
            OP_SETPOS: decoded.kind = CMD_SETPOS;
            OP_HOME:   decoded.kind = CMD_HOME;
            default:   decoded.kind = CMD_NOP;
        endcase
    end

    tcc_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (decoded),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_bits),
        .empty (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_bits);

endmodule
`default_nettype wire

// ===== rtl/core/tcc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_back
// executes commands: cursor moves, cell writes, line wrap and scroll
// ----------------------------------------------------------------------------
module tcc_back
    import tcc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire cmd_t cmd,
    input  wire logic cmd_empty,
    output logic      cmd_pop,
    output logic      res_push,
    output result_t   res,
    input  wire logic res_full
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    cmd_t       cmd_reg, cmd_next;
    logic [7:0] col_reg, col_next;
    logic [5:0] row_reg, row_next;
    logic [5:0] top_reg, top_next;

    logic [7:0] eff_cols;
    logic [6:0] eff_rows;
    logic [6:0] rows_m1;
    logic [6:0] row_sum;
    logic [5:0] row_phys;
    logic [6:0] top_inc;
    logic [5:0] top_scr;
    logic [6:0] clr_sum;
    logic [5:0] clr_phys;
    logic [7:0] col_inc;
    logic       at_bottom;
    logic       tab_end;
    logic       ready;
    result_t    cell_res;
    result_t    clear_res;

    // effective sizes, out-of-range register values clamp
    always_comb
    begin
        if (cfg.columns == 8'd0)
        begin
            eff_cols = 8'd1;
        end
        else if (cfg.columns > 8'(MAX_COLS))
        begin
            eff_cols = 8'(MAX_COLS);
        end
        else
        begin
            eff_cols = cfg.columns;
        end
        if (cfg.rows == 7'd0)
        begin
            eff_rows = 7'd1;
        end
        else if (cfg.rows > 7'(MAX_ROWS))
        begin
            eff_rows = 7'(MAX_ROWS);
        end
        else
        begin
            eff_rows = cfg.rows;
        end
    end

    assign rows_m1   = eff_rows - 7'd1;
    assign at_bottom = ({1'b0, row_reg} == rows_m1);
    assign ready     = !res_full;
    assign col_inc   = col_reg + 8'd1;
    assign tab_end   = ((col_inc % 8'(TAB_STOP)) == 8'd0) || (col_inc >= eff_cols);

    // logical to physical row, both operands below rows
    assign row_sum  = {1'b0, row_reg} + {1'b0, top_reg};
    assign row_phys = (row_sum >= eff_rows) ? 6'(row_sum - eff_rows) : row_sum[5:0];

    // offset after one scroll and the physical row of the new bottom line
    assign top_inc  = {1'b0, top_reg} + 7'd1;
    assign top_scr  = (top_inc >= eff_rows) ? 6'd0 : top_inc[5:0];
    assign clr_sum  = rows_m1 + {1'b0, top_scr};
    assign clr_phys = (clr_sum >= eff_rows) ? 6'(clr_sum - eff_rows) : clr_sum[5:0];

    always_comb
    begin
        cell_res.kind       = KIND_CELL;
        cell_res.screen_row = row_reg;
        cell_res.screen_col = col_reg[6:0];
        cell_res.store_row  = row_phys;
        cell_res.cell_char  = (cmd_reg.kind == CMD_TAB) ? CH_SPACE : cmd_reg.character;
        cell_res.cell_color = cfg.foreground_color;
        cell_res.last       = 1'b1;

        clear_res.kind       = KIND_CLEAR;
        clear_res.screen_row = rows_m1[5:0];
        clear_res.screen_col = 7'd0;
        clear_res.store_row  = clr_phys;
        clear_res.cell_char  = CH_SPACE;
        clear_res.cell_color = cfg.foreground_color;
        clear_res.last       = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        top_next   = top_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res        = cell_res;

        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    // row beyond a shrunk screen sits on the bottom line
                    if ({1'b0, row_reg} >= eff_rows)
                    begin
                        row_next = rows_m1[5:0];
                    end
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ({1'b0, top_reg} >= eff_rows)
                begin
                    // reduce the offset one subtraction per cycle
                    top_next = 6'({1'b0, top_reg} - eff_rows);
                end
                else
                begin
                    case (cmd_reg.kind)
                        CMD_PRINT:
                        begin
                            if (col_reg >= eff_cols)
                            begin
                                // wrap first, write on the next pass
                                if (at_bottom)
                                begin
                                    if (ready)
                                    begin
                                        res          = clear_res;
                                        res.last     = 1'b0;
                                        res_push     = 1'b1;
                                        top_next     = top_scr;
                                        col_next     = 8'd0;
                                    end
                                end
                                else
                                begin
                                    col_next = 8'd0;
                                    row_next = row_reg + 6'd1;
                                end
                            end
                            else if (ready)
                            begin
                                res_push   = 1'b1;
                                col_next   = col_inc;
                                state_next = ST_IDLE;
                            end
                        end
                        CMD_LF:
                        begin
                            if (at_bottom)
                            begin
                                if (ready)
                                begin
                                    res        = clear_res;
                                    res_push   = 1'b1;
                                    top_next   = top_scr;
                                    col_next   = 8'd0;
                                    state_next = ST_IDLE;
                                end
                            end
                            else
                            begin
                                col_next   = 8'd0;
                                row_next   = row_reg + 6'd1;
                                state_next = ST_IDLE;
                            end
                        end
                        CMD_CR:
                        begin
                            col_next   = 8'd0;
                            state_next = ST_IDLE;
                        end
                        CMD_BS:
                        begin
                            if (col_reg != 8'd0)
                            begin
                                col_next = col_reg - 8'd1;
                            end
                            state_next = ST_IDLE;
                        end
                        CMD_TAB:
                        begin
                            if (col_reg >= eff_cols)
                            begin
                                state_next = ST_IDLE;
                            end
                            else if (ready)
                            begin
                                res_push = 1'b1;
                                res.last = tab_end;
                                col_next = col_inc;
                                if (tab_end)
                                begin
                                    state_next = ST_IDLE;
                                end
                            end
                        end
                        CMD_SETPOS:
                        begin
                            if ({1'b0, cmd_reg.pos_x} < eff_cols)
                            begin
                                col_next = {1'b0, cmd_reg.pos_x};
                            end
                            if ({1'b0, cmd_reg.pos_y} < eff_rows)
                            begin
                                row_next = cmd_reg.pos_y;
                            end
                            state_next = ST_IDLE;
                        end
                        CMD_HOME:
                        begin
                            col_next   = 8'd0;
                            row_next   = 6'd0;
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= 8'd0;
            row_reg   <= 6'd0;
            top_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule
`default_nettype wire

// ===== tb/tcc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_checker
// watches the item, result and register ports of the cursor engine, predicts
// the screen updates of every accepted item and compares them in order
// ----------------------------------------------------------------------------
module tcc_checker
    import tcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire item_t       item,
    input  wire logic        full,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire result_t     result,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    // shadow registers
    logic [7:0]  columns_reg;
    logic [6:0]  rows_reg;
    logic [23:0] color_shadow;

    // shadow cursor and scroll state
    logic [7:0]  cur_col;
    logic [5:0]  cur_row;
    logic [5:0]  top_offset;

    result_t     screen_updates[$];
    int          updates_this_item;
    result_t     want;

    function automatic int active_cols();
        if (columns_reg == 8'd0)
            return 1;
        if (int'(columns_reg) > MAX_COLS)
            return MAX_COLS;
        return int'(columns_reg);
    endfunction

    function automatic int active_rows();
        if (rows_reg == 7'd0)
            return 1;
        if (int'(rows_reg) > MAX_ROWS)
            return MAX_ROWS;
        return int'(rows_reg);
    endfunction

    function automatic string fmt_update(input result_t u);
        return $sformatf("kind=%0d row=%0d col=%0d store=%0d char=%h color=%h last=%0d",
                         u.kind, u.screen_row, u.screen_col, u.store_row,
                         u.cell_char, u.cell_color, u.last);
    endfunction

    task automatic report_update(input logic kind, input int srow, input int scol,
                                 input int prow, input logic [7:0] ch);
        result_t u;
        u.kind       = kind;
        u.screen_row = 6'(srow);
        u.screen_col = 7'(scol);
        u.store_row  = 6'(prow);
        u.cell_char  = ch;
        u.cell_color = color_shadow;
        u.last       = 1'b0;
        screen_updates.push_back(u);
        updates_this_item++;
    endtask

    // rotate the offset, the new bottom row is cleared
    task automatic rotate_screen();
        int r;
        r = active_rows();
        top_offset = 6'((int'(top_offset) + 1) % r);
        report_update(KIND_CLEAR, r - 1, 0, (r - 1 + int'(top_offset)) % r, CH_SPACE);
    endtask

    task automatic next_line();
        int r;
        r = active_rows();
        cur_col = 8'd0;
        if (int'(cur_row) + 1 >= r)
        begin
            cur_row = 6'(r - 1);
            rotate_screen();
        end
        else
            cur_row = cur_row + 6'd1;
    endtask

    task automatic write_cell(input logic [7:0] ch);
        int r;
        if (int'(cur_col) >= active_cols())
            next_line();
        r = active_rows();
        report_update(KIND_CELL, int'(cur_row), int'(cur_col),
                      (int'(cur_row) + int'(top_offset)) % r, ch);
        cur_col = cur_col + 8'd1;
    endtask

    task automatic apply_console_item(input item_t it);
        int      r;
        int      c;
        int      stop;
        result_t tail;
        r = active_rows();
        c = active_cols();
        updates_this_item = 0;
        // state left over from a larger screen
        if (int'(cur_row) >= r)
            cur_row = 6'(r - 1);
        top_offset = 6'(int'(top_offset) % r);
        case (it.operation)
            OP_PUT:
            begin
                case (it.character)
                    CH_LF:  next_line();
                    CH_CR:  cur_col = 8'd0;
                    CH_BS:
                    begin
                        if (cur_col != 8'd0)
                            cur_col = cur_col - 8'd1;
                    end
                    CH_TAB:
                    begin
                        stop = (int'(cur_col) / TAB_STOP + 1) * TAB_STOP;
                        while (int'(cur_col) < stop && int'(cur_col) < c)
                            write_cell(CH_SPACE);
                    end
                    default: write_cell(it.character);
                endcase
            end
            OP_SETPOS:
            begin
                if (int'(it.pos_x) < c)
                    cur_col = {1'b0, it.pos_x};
                if (int'(it.pos_y) < r)
                    cur_row = it.pos_y;
            end
            OP_HOME:
            begin
                cur_col = 8'd0;
                cur_row = 6'd0;
            end
            default: ;
        endcase
        if (updates_this_item > 0)
        begin
            tail = screen_updates.pop_back();
            tail.last = 1'b1;
            screen_updates.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg  = COLUMNS_RESET;
            rows_reg     = ROWS_RESET;
            color_shadow = FG_RESET;
            cur_col      = 8'd0;
            cur_row      = 6'd0;
            top_offset   = 6'd0;
            screen_updates.delete();
            pending      = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (screen_updates.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %s",
                             $time, fmt_update(result));
                end
                else
                begin
                    want = screen_updates.pop_front();
                    if (result !== want)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected %s", $time, fmt_update(want));
                        $display("%0t:            actual %s", $time, fmt_update(result));
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_COLUMNS: columns_reg  = cfg_data[7:0];
                    REG_ROWS:    rows_reg     = cfg_data[6:0];
                    REG_FG:      color_shadow = cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
                apply_console_item(item);
            pending = screen_updates.size();
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// drives characters and cursor commands into the text console cursor engine
// under several screen sizes, with random gaps on both queues; the checker
// beside the block predicts every cell write and row clear
// ----------------------------------------------------------------------------
module tb_top;
    import tcc_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    // covers the item latency and an offset reduction over a full screen
    localparam int SETTLE_CYCLES   = 100;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 44;
    // the one operation code the engine ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        push;
    item_t       item;
    logic        full;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    int          fail_count;
    int          pending;
    int          cycle_count;
    // random idling on both sides while set
    bit          gaps_on;

    text_console_cursor_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tcc_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // result side: pop high, with random stall bursts while gaps are on
    initial
    begin
        int stall;
        stall = 0;
        pop <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(0, 8);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    function automatic item_t make_item(input logic [1:0] op, input logic [7:0] ch,
                                        input logic [6:0] x, input logic [5:0] y);
        item_t it;
        it.operation = op;
        it.character = ch;
        it.pos_x     = x;
        it.pos_y     = y;
        return it;
    endfunction

    // mostly printable bytes and line control, some cursor moves and noise
    function automatic item_t random_console_item();
        item_t it;
        int    pick;
        it = make_item(OP_PUT, 8'($urandom), 7'($urandom), 6'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            if ($urandom_range(0, 3) != 0)
                it.character = 8'($urandom_range(32, 126));
        end
        else if (pick < 77)
        begin
            case ($urandom_range(0, 4))
                0, 1:    it.character = CH_LF;
                2:       it.character = CH_CR;
                3:       it.character = CH_BS;
                default: it.character = CH_TAB;
            endcase
        end
        else if (pick < 89)
        begin
            it.operation = OP_SETPOS;
            // small coordinates land inside small screens
            if ($urandom_range(0, 1) == 0)
            begin
                it.pos_x = 7'($urandom_range(0, 9));
                it.pos_y = 6'($urandom_range(0, 5));
            end
        end
        else if (pick < 95)
            it.operation = OP_HOME;
        else
            it.operation = OP_UNUSED;
        return it;
    endfunction

    // hold the item on the port until the engine takes it; returns on a falling edge
    task automatic send_item(input item_t it);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // every expected result in, then room for items that report nothing
    task automatic wait_idle();
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // all three registers, written back to back while the engine is idle
    task automatic write_config(input logic [7:0] cols, input logic [6:0] nrows,
                                input logic [23:0] fg);
        push <= 1'b0;
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= REG_COLUMNS;
        cfg_data  <= {16'd0, cols};
        @(negedge clk);
        cfg_index <= REG_ROWS;
        cfg_data  <= {17'd0, nrows};
        @(negedge clk);
        cfg_index <= REG_FG;
        cfg_data  <= fg;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        push      <= 1'b0;
        item      <= '0;
        cfg_write <= 1'b0;
        cfg_index <= REG_COLUMNS;
        cfg_data  <= 24'd0;
        rst_n     <= 1'b0;
        gaps_on    = 1'b1;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part on the reset screen of 80 x 25
        send_item(make_item(OP_PUT, 8'h41, 7'd0, 6'd0));
        send_item(make_item(OP_PUT, 8'hFF, 7'h7F, 6'h3F));
        send_item(make_item(OP_PUT, 8'h00, 7'd0, 6'd0));
        // tab from column 3 fills one cell
        send_item(make_item(OP_PUT, CH_TAB, 7'd0, 6'd0));
        send_item(make_item(OP_PUT, CH_BS, 7'd0, 6'd0));
        send_item(make_item(OP_PUT, CH_CR, 7'd0, 6'd0));
        // backspace at column 0 stays put
        send_item(make_item(OP_PUT, CH_BS, 7'd0, 6'd0));
        send_item(make_item(OP_PUT, CH_LF, 7'd0, 6'd0));
        // both coordinates out of range, ignored
        send_item(make_item(OP_SETPOS, 8'hFF, 7'h7F, 6'h3F));
        send_item(make_item(OP_SETPOS, 8'h00, 7'd78, 6'd24));
        // tab up to the right edge, then a tab with no room left
        send_item(make_item(OP_PUT, CH_TAB, 7'd0, 6'd0));
        send_item(make_item(OP_PUT, CH_TAB, 7'd0, 6'd0));
        // wrap on the bottom row scrolls before the write
        send_item(make_item(OP_PUT, 8'h7A, 7'd0, 6'd0));
        send_item(make_item(OP_PUT, CH_LF, 7'd0, 6'd0));
        send_item(make_item(OP_UNUSED, 8'hFF, 7'h7F, 6'h3F));
        send_item(make_item(OP_HOME, 8'hFF, 7'h7F, 6'h3F));
        send_item(make_item(OP_PUT, 8'h7E, 7'd0, 6'd0));
        // wrap in the middle of the screen, no scroll
        send_item(make_item(OP_SETPOS, 8'h00, 7'd79, 6'd0));
        send_item(make_item(OP_PUT, 8'h71, 7'd0, 6'd0));
        send_item(make_item(OP_PUT, 8'h72, 7'd0, 6'd0));
        send_item(make_item(OP_SETPOS, 8'h00, 7'd0, 6'd0));

        // random part, one screen setting per phase, extremes included;
        // the register writes also make the sender wait for every result
        for (int phase = 0; phase < PHASES; phase++)
        begin
            gaps_on = (phase != 4) && (phase < 8);
            case (phase)
                0:       write_config(8'd8, 7'd4, 24'($urandom));
                1:       write_config(8'd1, 7'd1, 24'h000000);
                2:       write_config(8'd0, 7'd0, 24'hFFFFFF);
                3:       write_config(8'd255, 7'd127, 24'($urandom));
                4:       write_config(8'd128, 7'd64, 24'($urandom));
                5:       write_config(8'd5, 7'd2, 24'($urandom));
                6:       write_config(8'($urandom_range(1, 20)), 7'($urandom_range(1, 8)),
                                      24'($urandom));
                7:       write_config(COLUMNS_RESET, ROWS_RESET, FG_RESET);
                8:       write_config(8'($urandom), 7'($urandom), 24'($urandom));
                default: write_config(8'd4, 7'd3, 24'($urandom));
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(random_console_item());
        end

        push <= 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
